@@ hw/rtl/aesbe_pkg.sv @@
// ----------------------------------------------------------------------------
// AES block encrypt package
// Shared constants, types and GF(2^8) helpers for the AES encrypt unit.
// ----------------------------------------------------------------------------
`default_nettype none

package aesbe_pkg;

    // Default size of the round key store, in 32-bit words.
    localparam int KEY_WORDS_DEF = 60;

    // Columns in the AES state, one cell each.
    localparam int NUM_COLS = 4;

    // Round counts for the key size codes.
    localparam logic [3:0] ROUNDS_128 = 4'd10;
    localparam logic [3:0] ROUNDS_192 = 4'd12;
    localparam logic [3:0] ROUNDS_256 = 4'd14;

    // Key size register codes.
    localparam logic [1:0] KSZ_128    = 2'd0;
    localparam logic [1:0] KSZ_192    = 2'd1;
    localparam logic [1:0] KSZ_256    = 2'd2;
    localparam logic [1:0] KSZ_UNUSED = 2'd3;

    // Input item operation codes.
    localparam logic OP_KEY_WRITE = 1'b0;
    localparam logic OP_ENCRYPT   = 1'b1;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Control handed to every column cell.
    typedef struct packed {
        logic load;   // take the plaintext column
        logic en;     // perform one step
        logic first;  // initial key addition only
        logic last;   // final round, no column mix
    } cell_ctl_t;

    // Forward S-box.
    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // Multiply by two in GF(2^8).
    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Round count selected by the key size register; the unused code acts as 128-bit.
    function automatic logic [3:0] rounds_for(input logic [1:0] ksz);
        logic [3:0] r;
        case (ksz)
            KSZ_192: r = ROUNDS_192;
            KSZ_256: r = ROUNDS_256;
            default: r = ROUNDS_128;
        endcase
        rounds_for = r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/aesbe_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aesbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 15,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/aesbe_cell.sv @@
// ----------------------------------------------------------------------------
// AES column cell
// Holds one state column and computes one round step on it per cycle while
// enabled, from the row-shifted bytes that its neighbors hand over.
// ----------------------------------------------------------------------------
`default_nettype none

module aesbe_cell (
    input  wire logic                  aclk,
    input  wire aesbe_pkg::cell_ctl_t  ctl,
    input  wire logic [31:0]           plain_col,
    input  wire logic [31:0]           shift_col,
    input  wire logic [31:0]           key_col,
    output logic      [31:0]           col_q,
    output logic      [31:0]           col_next
);

    logic [31:0] col_reg;
    logic [7:0]  sb [4];
    logic [7:0]  mx [4];
    logic [31:0] sub_col;
    logic [31:0] mix_col;

    // Byte substitution on the shifted column.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            sb[r] = aesbe_pkg::SBOX[shift_col[31-8*r -: 8]];
        end
        sub_col = {sb[0], sb[1], sb[2], sb[3]};
    end

    // Column mix.
    always_comb begin
        mx[0] = aesbe_pkg::xtime(sb[0]) ^ aesbe_pkg::xtime(sb[1]) ^ sb[1] ^ sb[2] ^ sb[3];
        mx[1] = sb[0] ^ aesbe_pkg::xtime(sb[1]) ^ aesbe_pkg::xtime(sb[2]) ^ sb[2] ^ sb[3];
        mx[2] = sb[0] ^ sb[1] ^ aesbe_pkg::xtime(sb[2]) ^ aesbe_pkg::xtime(sb[3]) ^ sb[3];
        mx[3] = aesbe_pkg::xtime(sb[0]) ^ sb[0] ^ sb[1] ^ sb[2] ^ aesbe_pkg::xtime(sb[3]);
        mix_col = {mx[0], mx[1], mx[2], mx[3]};
    end

    // Next column value.
    always_comb begin
        col_next = col_reg;
        if (ctl.load) begin
            col_next = plain_col;
        end else if (ctl.en) begin
            if (ctl.first) begin
                col_next = col_reg ^ key_col;
            end else if (ctl.last) begin
                col_next = sub_col ^ key_col;
            end else begin
                col_next = mix_col ^ key_col;
            end
        end
    end

    always_ff @(posedge aclk) begin
        col_reg <= col_next;
    end

    assign col_q = col_reg;

endmodule

`default_nettype wire

@@ hw/rtl/aes_block_encrypt_unit.sv @@
// ----------------------------------------------------------------------------
// AES block encrypt unit
// Encrypts 128-bit blocks with a preloaded round key schedule, one round per
// cycle unless the result register is full, in a ring of four column cells.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake              Content
//  s_       in   s_valid / s_ready      key word write or plaintext block
//  m_       out  m_valid / m_ready      ciphertext block
//  cfg_     in   cfg_valid / cfg_ready  key size code
//
// An encrypt item is loaded into the column cells when it is taken, then
// runs the initial key addition and one round per cycle, with the round
// keys read from four key banks one round ahead; the next item is taken
// only after the result register is loaded and the sequencer is idle again.
// Reset clears the sequencer, the output valid and the key size code; the
// key store keeps no reset value. When the result register is still full at
// the last round, the cells hold until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_block_encrypt_unit #(
    parameter int KEY_WORDS = aesbe_pkg::KEY_WORDS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data,
    // Input items
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_op,
    input  wire logic [5:0]  s_key_index,
    input  wire logic [31:0] s_key_word,
    input  wire logic [63:0] s_block_hi,
    input  wire logic [63:0] s_block_lo,
    // Result items
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_cipher_hi,
    output logic [63:0]      m_cipher_lo
);

    localparam int BANK_DEPTH = (KEY_WORDS + 3) / 4;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    aesbe_pkg::state_t    state_reg, state_next;
    logic [3:0]           rnd_reg, rnd_next;
    logic [3:0]           rounds_reg, rounds_next;
    logic [1:0]           ksz_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [63:0]          hi_reg, hi_next;
    logic [63:0]          lo_reg, lo_next;
    logic [3:0]           kvalid_reg, kvalid_next;

    logic                 in_acc;
    logic                 enc_start;
    logic                 key_wr;
    logic                 out_free;
    logic                 advance;
    logic [3:0]           rd_rnd;
    aesbe_pkg::cell_ctl_t ctl;

    logic [31:0]          plain_col [4];
    logic [31:0]          shift_col [4];
    logic [31:0]          key_col   [4];
    logic [31:0]          bank_q    [4];
    logic [31:0]          col_q     [4];
    logic [31:0]          col_next  [4];

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == aesbe_pkg::ST_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign enc_start = in_acc && (s_op == aesbe_pkg::OP_ENCRYPT);
    assign key_wr    = in_acc && (s_op == aesbe_pkg::OP_KEY_WRITE)
                       && ({1'b0, s_key_index} < 7'(KEY_WORDS));
    assign out_free  = !m_valid_reg || m_ready;

    // Key size register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ksz_reg <= aesbe_pkg::KSZ_128;
        end else if (cfg_valid && cfg_ready) begin
            ksz_reg <= cfg_data;
        end
    end

    // Sequencer: rounds step every cycle, the last one waits for the result register.
    always_comb begin
        state_next   = state_reg;
        rnd_next     = rnd_reg;
        rounds_next  = rounds_reg;
        m_valid_next = m_valid_reg && !m_ready;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        advance      = (rnd_reg != rounds_reg) || out_free;
        ctl          = '0;
        case (state_reg)
            aesbe_pkg::ST_IDLE: begin
                if (enc_start) begin
                    ctl.load    = 1'b1;
                    rnd_next    = 4'd0;
                    rounds_next = aesbe_pkg::rounds_for(ksz_reg);
                    state_next  = aesbe_pkg::ST_RUN;
                end
            end
            aesbe_pkg::ST_RUN: begin
                if (advance) begin
                    ctl.en    = 1'b1;
                    ctl.first = (rnd_reg == 4'd0);
                    ctl.last  = (rnd_reg == rounds_reg);
                    if (rnd_reg == rounds_reg) begin
                        m_valid_next = 1'b1;
                        hi_next      = {col_next[0], col_next[1]};
                        lo_next      = {col_next[2], col_next[3]};
                        state_next   = aesbe_pkg::ST_IDLE;
                    end else begin
                        rnd_next = rnd_reg + 4'd1;
                    end
                end
            end
            default: begin
                state_next = aesbe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= aesbe_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            rnd_reg     <= 4'd0;
            rounds_reg  <= aesbe_pkg::ROUNDS_128;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            rnd_reg     <= rnd_next;
            rounds_reg  <= rounds_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        kvalid_reg <= kvalid_next;
    end

    // Round whose keys are fetched this cycle for use in the next one.
    always_comb begin
        if (enc_start) begin
            rd_rnd = 4'd0;
        end else if (state_reg == aesbe_pkg::ST_RUN && advance) begin
            rd_rnd = rnd_reg + 4'd1;
        end else begin
            rd_rnd = rnd_reg;
        end
        for (int c = 0; c < 4; c++) begin
            kvalid_next[c] = ({1'b0, rd_rnd, 2'(c)} < 7'(KEY_WORDS));
        end
    end

    // Column split of the plaintext and row-shifted hand-over around the ring.
    always_comb begin
        plain_col[0] = s_block_hi[63:32];
        plain_col[1] = s_block_hi[31:0];
        plain_col[2] = s_block_lo[63:32];
        plain_col[3] = s_block_lo[31:0];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                shift_col[c][31-8*r -: 8] = col_q[(c + r) & 3][31-8*r -: 8];
            end
            key_col[c] = kvalid_reg[c] ? bank_q[c] : 32'h0;
        end
    end

    // One key bank per column and one cell per column.
    for (genvar c = 0; c < aesbe_pkg::NUM_COLS; c++) begin : g_col
        logic                we_c;
        logic [BANK_AW-1:0]  raddr_c;

        assign we_c    = key_wr && (s_key_index[1:0] == 2'(c));
        assign raddr_c = kvalid_next[c] ? rd_rnd[BANK_AW-1:0] : '0;

        aesbe_ram #(
            .WIDTH (32),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .aclk  (aclk),
            .we    (we_c),
            .waddr (s_key_index[2 +: BANK_AW]),
            .wdata (s_key_word),
            .raddr (raddr_c),
            .rdata (bank_q[c])
        );

        aesbe_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .plain_col (plain_col[c]),
            .shift_col (shift_col[c]),
            .key_col   (key_col[c]),
            .col_q     (col_q[c]),
            .col_next  (col_next[c])
        );
    end

    assign m_valid     = m_valid_reg;
    assign m_cipher_hi = hi_reg;
    assign m_cipher_lo = lo_reg;

endmodule

`default_nettype wire
